/* rtl/udw_pkg.sv */
// Shared types, widths and code constants for the display width block.
`default_nettype none
package udw_pkg;

    localparam int CP_W            = 21;
    localparam int IDX_W           = 9;
    localparam int CNT_W           = 10;
    localparam int REQ_W           = 2;
    localparam int WIDTH_W         = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = CNT_W;
    localparam int DEF_TABLE_DEPTH = 512;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLASSIFY = 2'd0,
        REQ_WR_ZERO  = 2'd1,
        REQ_WR_DBL   = 2'd2,
        REQ_NONE     = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_CNT = 2'd0,
        CFG_DBL_CNT  = 2'd1
    } t_cfg_idx;

    typedef logic [CP_W-1:0]           t_cp;
    typedef logic signed [WIDTH_W-1:0] t_width;

    localparam t_width W_CTRL   = -3'sd1;
    localparam t_width W_ZERO   = 3'sd0;
    localparam t_width W_NORMAL = 3'sd1;
    localparam t_width W_DOUBLE = 3'sd2;

    localparam t_cp CP_NUL      = 21'h000000;
    localparam t_cp CP_C0_LAST  = 21'h00001f;
    localparam t_cp CP_C1_FIRST = 21'h000080;
    localparam t_cp CP_C1_LAST  = 21'h00009f;
    localparam t_cp CP_CGJ      = 21'h00034f;
    localparam t_cp CP_ZWS_LO   = 21'h00200b;
    localparam t_cp CP_ZWS_HI   = 21'h00200f;
    localparam t_cp CP_SEP_LO   = 21'h002028;
    localparam t_cp CP_SEP_HI   = 21'h00202e;
    localparam t_cp CP_WJ_LO    = 21'h002060;
    localparam t_cp CP_WJ_HI    = 21'h002063;

    // joiners, separators and direction marks that are always zero width
    function automatic logic in_fixed_list(input t_cp c);
        logic hit;
        hit = (c == CP_CGJ)
           || (c >= CP_ZWS_LO && c <= CP_ZWS_HI)
           || (c >= CP_SEP_LO && c <= CP_SEP_HI)
           || (c >= CP_WJ_LO  && c <= CP_WJ_HI);
        return hit;
    endfunction

endpackage
`default_nettype wire

/* rtl/udw_if.sv */
// Request and result channel interfaces of the display width block.
`default_nettype none
interface udw_req_if;
    import udw_pkg::*;

    logic             valid;
    logic             ready;
    t_req             req_type;
    logic [CP_W-1:0]  code_point;
    logic [CP_W-1:0]  range_end;
    logic [IDX_W-1:0] entry_index;

    modport source (output valid, output req_type, output code_point,
                    output range_end, output entry_index, input ready);
    modport sink   (input valid, input req_type, input code_point,
                    input range_end, input entry_index, output ready);
endinterface

interface udw_res_if;
    import udw_pkg::*;

    logic   valid;
    logic   ready;
    t_width width;

    modport source (output valid, output width, input ready);
    modport sink   (input valid, input width, output ready);
endinterface
`default_nettype wire

/* rtl/unicode_display_width_core.sv */
// Top level: display column width of a code point, with two range tables.
//
// Each request word is a classify word, a table write or an unused word that
// is dropped. A table write (zero-width or double-width table) stores begin
// and inclusive end at entry_index (slots at or above TABLE_DEPTH are dropped)
// and gives no result; the block stays ready. A classify word gives one result
// word. Null, controls, ASCII and the fixed list of joiners and direction
// marks are settled in one pass. Other code points run a binary search over
// the zero-width table, and on a miss over the double-width table, both on one
// shared 21-bit compare unit and one registered memory read per table. Each
// probe issues the address, then compares; the live entries of a table are its
// count, capped at TABLE_DEPTH. The search ends with a check of the begin.
// The block is not ready while a classify word is in flight; it accepts the
// next word while the result still waits in the output register. The user
// must write counts through the config port only while idle; the block itself
// does not enforce it; tables are not cleared at reset and must be loaded
// before the counts cover them.
`default_nettype none
module unicode_display_width_core #(
    parameter int TABLE_DEPTH = udw_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    udw_req_if.sink                             i_req,
    udw_res_if.source                           o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [udw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [udw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import udw_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);     // table address
    localparam int NW    = AW + 1;                  // holds 0..TABLE_DEPTH
    localparam int CMPW  = (NW > CNT_W) ? NW : CNT_W;
    localparam int IXW   = (AW > IDX_W) ? AW : IDX_W;
    localparam int ENT_W = 2 * CP_W;                // {begin, end}

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PRE    = 6'b000010,   // fixed classes
        S_SEARCH = 6'b000100,   // issue probe address
        S_CMP    = 6'b001000,   // end[mid] < code ?
        S_HIT    = 6'b010000,   // code >= begin[lo] ?
        S_EMIT   = 6'b100000    // wait for output register
    } t_state;

    typedef enum logic {
        TBL_ZERO = 1'b0,
        TBL_DBL  = 1'b1
    } t_tbl;

    // control state
    t_state r_state, n_state;
    t_tbl   r_tbl, n_tbl;
    logic   r_ov, n_ov;
    logic [CNT_W-1:0] r_zero_cnt, r_dbl_cnt;

    // datapath
    t_cp             r_code, n_code;
    logic [NW-1:0]   r_lo, n_lo;
    logic [NW-1:0]   r_hi, n_hi;
    logic [NW-1:0]   r_n, n_n;
    logic [AW-1:0]   r_mid, n_mid;
    t_width          r_res, n_res;
    t_width          r_width, n_width;

    // range tables
    logic [ENT_W-1:0] r_zero_mem [TABLE_DEPTH];
    logic [ENT_W-1:0] r_dbl_mem  [TABLE_DEPTH];
    logic [ENT_W-1:0] r_zero_rd, r_dbl_rd;

    logic             in_acc, slot_free;
    logic             wr_ok;
    logic [IXW-1:0]   idx_ext;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [ENT_W-1:0] wr_data, rd_ent;
    logic [NW:0]      mid_sum;
    logic [AW-1:0]    mid;
    logic [NW-1:0]    n_zero_lim, n_dbl_lim;
    t_cp              cmp_a, cmp_b;
    logic             cmp_lt;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid & i_req.ready;
    assign slot_free   = ~r_ov | o_res.ready;
    assign o_res.valid = r_ov;
    assign o_res.width = r_width;

    // live entry counts, capped at the table depth
    assign n_zero_lim = (CMPW'(r_zero_cnt) > CMPW'(TABLE_DEPTH))
                      ? NW'(TABLE_DEPTH) : NW'(r_zero_cnt);
    assign n_dbl_lim  = (CMPW'(r_dbl_cnt) > CMPW'(TABLE_DEPTH))
                      ? NW'(TABLE_DEPTH) : NW'(r_dbl_cnt);

    // write side
    assign idx_ext = IXW'(i_req.entry_index);
    assign wr_addr = idx_ext[AW-1:0];
    assign wr_ok   = CMPW'(i_req.entry_index) < CMPW'(TABLE_DEPTH);
    assign wr_data = {i_req.code_point, i_req.range_end};

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[AW:1];

    assign rd_ent  = (r_tbl == TBL_DBL) ? r_dbl_rd : r_zero_rd;

    // shared compare unit: end < code while probing, code < begin at the end
    always_comb begin
        if (r_state == S_HIT) begin
            cmp_a = r_code;
            cmp_b = rd_ent[ENT_W-1:CP_W];
        end else begin
            cmp_a = rd_ent[CP_W-1:0];
            cmp_b = r_code;
        end
    end
    assign cmp_lt = cmp_a < cmp_b;

    always_comb begin
        n_state = r_state;
        n_tbl   = r_tbl;
        n_code  = r_code;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_n     = r_n;
        n_mid   = r_mid;
        n_res   = r_res;
        n_width = r_width;
        n_ov    = r_ov & ~o_res.ready;
        rd_addr = mid;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_req.req_type == REQ_CLASSIFY) begin
                    n_code  = i_req.code_point;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                n_state = S_EMIT;
                if (r_code == CP_NUL) begin
                    n_res = W_ZERO;
                end else if (r_code <= CP_C0_LAST ||
                             (r_code >= CP_C1_FIRST && r_code <= CP_C1_LAST)) begin
                    n_res = W_CTRL;
                end else if (r_code < CP_C1_FIRST) begin
                    n_res = W_NORMAL;
                end else if (in_fixed_list(r_code)) begin
                    n_res = W_ZERO;
                end else begin
                    n_tbl   = TBL_ZERO;
                    n_lo    = '0;
                    n_hi    = n_zero_lim;
                    n_n     = n_zero_lim;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    rd_addr = mid;
                    n_mid   = mid;
                    n_state = S_CMP;
                end else if (r_lo < r_n) begin
                    rd_addr = r_lo[AW-1:0];
                    n_state = S_HIT;
                end else if (r_tbl == TBL_ZERO) begin
                    n_tbl = TBL_DBL;
                    n_lo  = '0;
                    n_hi  = n_dbl_lim;
                    n_n   = n_dbl_lim;
                end else begin
                    n_res   = W_NORMAL;
                    n_state = S_EMIT;
                end
            end
            S_CMP: begin
                if (cmp_lt) begin
                    n_lo = {1'b0, r_mid} + NW'(1);
                end else begin
                    n_hi = {1'b0, r_mid};
                end
                n_state = S_SEARCH;
            end
            S_HIT: begin
                if (!cmp_lt) begin
                    n_res   = (r_tbl == TBL_ZERO) ? W_ZERO : W_DOUBLE;
                    n_state = S_EMIT;
                end else if (r_tbl == TBL_ZERO) begin
                    // miss in zero-width table: go on with double-width
                    n_tbl   = TBL_DBL;
                    n_lo    = '0;
                    n_hi    = n_dbl_lim;
                    n_n     = n_dbl_lim;
                    n_state = S_SEARCH;
                end else begin
                    n_res   = W_NORMAL;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_width = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tbl   <= TBL_ZERO;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tbl   <= n_tbl;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_n     <= n_n;
        r_mid   <= n_mid;
        r_res   <= n_res;
        r_width <= n_width;
    end

    // count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_cnt <= '0;
            r_dbl_cnt  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ZERO_CNT: r_zero_cnt <= i_cfg_data;
                CFG_DBL_CNT:  r_dbl_cnt  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // zero-width table
    always_ff @(posedge i_clk) begin
        if (in_acc && i_req.req_type == REQ_WR_ZERO && wr_ok) begin
            r_zero_mem[wr_addr] <= wr_data;
        end
        r_zero_rd <= r_zero_mem[rd_addr];
    end

    // double-width table
    always_ff @(posedge i_clk) begin
        if (in_acc && i_req.req_type == REQ_WR_DBL && wr_ok) begin
            r_dbl_mem[wr_addr] <= wr_data;
        end
        r_dbl_rd <= r_dbl_mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/udw_checker.sv */
// Port-level assertions for the display width block, with its bind.
`default_nettype none
module udw_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic [udw_pkg::REQ_W-1:0]    i_in_req_type,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [udw_pkg::WIDTH_W-1:0]  i_out_width
);
    import udw_pkg::*;

    // a pending result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_width))
        else $error("result word dropped or changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_width_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_width == 3'b111 || i_out_width == 3'b000 ||
                         i_out_width == 3'b001 || i_out_width == 3'b010))
        else $error("width outside -1..2");

    // a classify word occupies the sequencer
    a_cls_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_req_type == REQ_CLASSIFY |=> !i_in_ready)
        else $error("ready while classify word in flight");

    // table writes and unused words leave the block ready
    a_wr_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_req_type != REQ_CLASSIFY |=> i_in_ready)
        else $error("not ready after table write");

endmodule

bind unicode_display_width_core udw_checker u_udw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_in_req_type (i_req.req_type),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_width   (o_res.width)
);
`default_nettype wire

/* bench/udw_width_checker.sv */
// Checker: watches both channels and the count port, predicts each width word and compares.
`default_nettype none
module udw_width_checker #(
    parameter int TABLE_DEPTH = udw_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    udw_req_if                                  i_req,
    udw_res_if                                  i_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [udw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [udw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fails,
    output int                                  o_pending
);
    import udw_pkg::*;

    t_cp              zero_lo [TABLE_DEPTH];
    t_cp              zero_hi [TABLE_DEPTH];
    t_cp              dbl_lo  [TABLE_DEPTH];
    t_cp              dbl_hi  [TABLE_DEPTH];
    logic [CNT_W-1:0] zero_cnt;
    logic [CNT_W-1:0] dbl_cnt;
    t_width           width_due [$];
    int               fails = 0;

    function automatic logic always_zero(input t_cp c);
        return (c == CP_CGJ)
            || (c >= CP_ZWS_LO && c <= CP_ZWS_HI)
            || (c >= CP_SEP_LO && c <= CP_SEP_HI)
            || (c >= CP_WJ_LO  && c <= CP_WJ_HI);
    endfunction

    // lower-bound search on range ends, then a check against the begin
    function automatic logic range_hit(input logic use_dbl, input t_cp c);
        int  n;
        int  lo;
        int  hi;
        int  mid;
        t_cp e;
        n  = use_dbl ? int'(dbl_cnt) : int'(zero_cnt);
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            e   = use_dbl ? dbl_hi[mid] : zero_hi[mid];
            if (e < c) lo = mid + 1;
            else       hi = mid;
        end
        if (lo >= n) return 1'b0;
        return c >= (use_dbl ? dbl_lo[lo] : zero_lo[lo]);
    endfunction

    function automatic t_width predict_width(input t_cp c);
        if (c == CP_NUL) return W_ZERO;
        if (c <= CP_C0_LAST || (c >= CP_C1_FIRST && c <= CP_C1_LAST)) return W_CTRL;
        if (c < CP_C1_FIRST) return W_NORMAL;
        if (always_zero(c)) return W_ZERO;
        if (range_hit(1'b0, c)) return W_ZERO;
        if (range_hit(1'b1, c)) return W_DOUBLE;
        return W_NORMAL;
    endfunction

    always @(posedge i_clk) begin : watch
        t_width want;
        if (!i_rst_n) begin
            zero_cnt = '0;
            dbl_cnt  = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ZERO_CNT: zero_cnt = i_cfg_data;
                    CFG_DBL_CNT:  dbl_cnt  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.req_type)
                    REQ_CLASSIFY: width_due.push_back(predict_width(i_req.code_point));
                    REQ_WR_ZERO: begin
                        if (int'(i_req.entry_index) < TABLE_DEPTH) begin
                            zero_lo[i_req.entry_index] = i_req.code_point;
                            zero_hi[i_req.entry_index] = i_req.range_end;
                        end
                    end
                    REQ_WR_DBL: begin
                        if (int'(i_req.entry_index) < TABLE_DEPTH) begin
                            dbl_lo[i_req.entry_index] = i_req.code_point;
                            dbl_hi[i_req.entry_index] = i_req.range_end;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (width_due.size() == 0) begin
                    fails++;
                    $error("width: expected none, actual %0d", i_res.width);
                end else begin
                    want = width_due.pop_front();
                    if (i_res.width !== want) begin
                        fails++;
                        $error("width: expected %0d, actual %0d", want, i_res.width);
                    end
                end
            end
        end
        o_fails   <= fails;
        o_pending <= width_due.size();
    end

endmodule
`default_nettype wire

/* bench/unicode_display_width_core_tb.sv */
// Testbench top: drives request words and count writes into the width block and reports.
`default_nettype none
module unicode_display_width_core_tb;
    import udw_pkg::*;

    localparam int TABLE_DEPTH     = DEF_TABLE_DEPTH;
    localparam int RESET_CYCLES    = 12;
    // classify words take longest with both tables full
    localparam int SETTLE_CYCLES   = 64;
    localparam int RX_HOLD_CYCLES  = 400;
    // longest quiet stretch of a correct run is the receiver hold-off above
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int N_PHASES        = 10;
    localparam int PHASE_WORDS     = 62;

    // register indexes past the two count registers: writes there do nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [CNT_W-1:0]     CNT_MAX     = '1;
    localparam t_cp                  CP_TOP      = '1;

    // null, control edges, ASCII top, fixed-list edges, top of the code space
    localparam int  N_EDGES = 14;
    localparam t_cp EDGE_CODES [N_EDGES] = '{
        CP_NUL, CP_C0_LAST, 21'h00007f, CP_C1_FIRST, CP_C1_LAST, 21'h0000a0, CP_CGJ,
        CP_ZWS_LO, CP_ZWS_HI, CP_SEP_LO, CP_SEP_HI, CP_WJ_LO, CP_WJ_HI, CP_TOP
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fails;
    int                    pending;
    logic                  rx_hold_req;
    logic                  rx_hold_done;
    int                    tx_quiet;
    int                    rx_quiet;
    int                    rx_gap;
    int                    stall_cnt = 0;

    // what has been written so far: steers code points onto range edges
    t_cp              sh_zb [TABLE_DEPTH];
    t_cp              sh_ze [TABLE_DEPTH];
    t_cp              sh_db [TABLE_DEPTH];
    t_cp              sh_de [TABLE_DEPTH];
    logic [CNT_W-1:0] sh_zc;
    logic [CNT_W-1:0] sh_dc;

    udw_req_if req_ch();
    udw_res_if res_ch();

    unicode_display_width_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    udw_width_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .i_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // idle length: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // entries the lookup actually searches
    function automatic int live(input logic [CNT_W-1:0] c);
        return (int'(c) > TABLE_DEPTH) ? TABLE_DEPTH : int'(c);
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 10'd1;
            2, 3, 4: return 10'($urandom_range(2, 24));
            default: return 10'($urandom_range(25, 1023));
        endcase
    endfunction

    // code point for a classify word: mostly on or next to live range edges
    function automatic t_cp pick_code();
        int  r;
        int  n;
        int  k;
        t_cp b;
        t_cp e;
        t_cp c;
        r = $urandom_range(0, 99);
        c = t_cp'($urandom);
        if (r < 70) begin
            n = (r < 38) ? live(sh_zc) : live(sh_dc);
            if (n > 0) begin
                k = $urandom_range(0, n - 1);
                b = (r < 38) ? sh_zb[k] : sh_db[k];
                e = (r < 38) ? sh_ze[k] : sh_de[k];
                case ($urandom_range(0, 4))
                    0:       c = b - 21'd1;
                    1:       c = b;
                    2:       c = e;
                    3:       c = e + 21'd1;
                    default: c = (e >= b) ? b + t_cp'($urandom_range(0, int'(e - b))) : b;
                endcase
            end
        end else if (r < 82) begin
            c = EDGE_CODES[$urandom_range(0, N_EDGES - 1)] + t_cp'($urandom_range(0, 2)) - 21'd1;
        end else if (r < 88) begin
            c = t_cp'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // offer one word, return at the edge that takes it
    task automatic send_word(input t_req rq, input t_cp cp, input t_cp re,
                             input logic [IDX_W-1:0] idx);
        int gap;
        if (tx_quiet > 0) begin
            tx_quiet--;
            gap = 0;
        end else begin
            gap = gap_len();
            if ($urandom_range(0, 63) == 0) tx_quiet = $urandom_range(30, 120);
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rq;
        req_ch.code_point  <= cp;
        req_ch.range_end   <= re;
        req_ch.entry_index <= idx;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        if (rq == REQ_WR_ZERO) begin
            sh_zb[idx] = cp;
            sh_ze[idx] = re;
        end else if (rq == REQ_WR_DBL) begin
            sh_db[idx] = cp;
            sh_de[idx] = re;
        end
    endtask

    // sorted, non-overlapping ranges into slots first.., now and then one reversed
    task automatic load_ranges(input logic to_dbl, input int first, input int num,
                               input int base, input int scale);
        int cursor;
        int b;
        int e;
        int tmp;
        int i;
        cursor = base;
        for (i = first; i < first + num; i++) begin
            b      = cursor + $urandom_range(1, scale);
            e      = b + $urandom_range(0, scale);
            cursor = e;
            if ($urandom_range(0, 31) == 0) begin
                tmp = b;
                b   = e;
                e   = tmp;
            end
            if (to_dbl) send_word(REQ_WR_DBL, t_cp'(b), t_cp'(e), IDX_W'(i));
            else        send_word(REQ_WR_ZERO, t_cp'(b), t_cp'(e), IDX_W'(i));
        end
    endtask

    // one random word: mostly classify, some table writes and unused requests
    task automatic send_random();
        int               r;
        int               n;
        t_req             rq;
        logic [IDX_W-1:0] idx;
        r   = $urandom_range(0, 99);
        idx = IDX_W'($urandom);
        if (r < 8) begin
            if (r < 4) begin
                rq = REQ_WR_ZERO;
                n  = live(sh_zc);
            end else begin
                rq = REQ_WR_DBL;
                n  = live(sh_dc);
            end
            // half of them land past the live entries and leave lookups alone
            if (r[0] && n < TABLE_DEPTH) idx = IDX_W'($urandom_range(n, TABLE_DEPTH - 1));
            send_word(rq, t_cp'($urandom), t_cp'($urandom), idx);
        end else if (r < 10) begin
            send_word(REQ_NONE, t_cp'($urandom), t_cp'($urandom), idx);
        end else begin
            send_word(REQ_CLASSIFY, pick_code(), t_cp'($urandom), idx);
        end
    endtask

    // stop offering, wait until every width word is back; settle covers an
    // in-flight word that answers nothing
    task automatic wait_drained(input logic settle);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random back-pressure, quiet stretches, and one long hold-off
    // on request while the sender keeps offering, so the block backs up
    initial begin
        res_ch.ready <= 1'b0;
        rx_hold_done <= 1'b0;
        rx_quiet = 0;
        rx_gap   = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req && !rx_hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_done <= 1'b1;
            end else if (rx_gap > 0) begin
                res_ch.ready <= 1'b0;
                rx_gap--;
            end else begin
                res_ch.ready <= 1'b1;
                if (rx_quiet > 0) begin
                    rx_quiet--;
                end else begin
                    rx_gap = gap_len();
                    if ($urandom_range(0, 63) == 0) rx_quiet = $urandom_range(30, 120);
                end
            end
        end
    end

    // no word moved on either channel for too long: the block is hung
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_CYCLES) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stim
        int               ph;
        int               k;
        logic [CNT_W-1:0] zc;
        logic [CNT_W-1:0] dc;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_ZERO_CNT;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_CLASSIFY;
        req_ch.code_point  <= '0;
        req_ch.range_end   <= '0;
        req_ch.entry_index <= '0;
        rx_hold_req        <= 1'b0;
        tx_quiet = 0;
        sh_zc    = '0;
        sh_dc    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: both tables empty, so only the fixed rules answer
        for (k = 0; k < N_EDGES; k++)
            send_word(REQ_CLASSIFY, EDGE_CODES[k], t_cp'($urandom), IDX_W'($urandom));
        send_word(REQ_NONE, t_cp'($urandom), t_cp'($urandom), IDX_W'($urandom));

        // two entries per table: second zero entry reversed, second double entry
        // reaches past the end of Unicode
        send_word(REQ_WR_ZERO, 21'h000300, 21'h00036f, 9'd0);
        send_word(REQ_WR_ZERO, 21'h002000, 21'h001fff, 9'd1);
        send_word(REQ_WR_DBL,  21'h001100, 21'h00115f, 9'd0);
        send_word(REQ_WR_DBL,  21'h10ffff, CP_TOP,     9'd1);
        wait_drained(1'b1);
        cfg_write(CFG_ZERO_CNT, 10'd2);
        cfg_write(CFG_DBL_CNT, 10'd2);
        sh_zc = 10'd2;
        sh_dc = 10'd2;
        send_word(REQ_CLASSIFY, 21'h000300, '0, '0);
        send_word(REQ_CLASSIFY, 21'h00036f, '0, '0);
        send_word(REQ_CLASSIFY, 21'h000370, '0, '0);
        send_word(REQ_CLASSIFY, 21'h001100, '0, '0);
        send_word(REQ_CLASSIFY, 21'h002000, '0, '0);
        send_word(REQ_CLASSIFY, CP_TOP, '0, '0);

        // fill every slot of both tables once; from here on any count is safe
        load_ranges(1'b0, 0, TABLE_DEPTH, 21'h0000a0, 1000);
        load_ranges(1'b1, 0, TABLE_DEPTH, 21'h000100, 2040);

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin zc = CNT_MAX;          dc = 10'(TABLE_DEPTH); end
                1: begin zc = '0;               dc = CNT_MAX;          end
                2: begin zc = 10'(TABLE_DEPTH); dc = 10'd1;            end
                default: begin
                    zc = rand_count();
                    dc = rand_count();
                end
            endcase
            // small tables: sometimes a fresh dense set near the fixed list
            if (zc != 0 && zc <= 24 && $urandom_range(0, 1) == 1)
                load_ranges(1'b0, 0, int'(zc), $urandom_range(21'h0000a0, 21'h002100),
                            $urandom_range(1, 64));
            if (dc != 0 && dc <= 24 && $urandom_range(0, 1) == 1)
                load_ranges(1'b1, 0, int'(dc), $urandom_range(21'h0000a0, 21'h002100),
                            $urandom_range(1, 64));
            wait_drained(1'b1);
            cfg_write(CFG_ZERO_CNT, zc);
            cfg_write(CFG_DBL_CNT, dc);
            if (ph >= 3 && $urandom_range(0, 1) == 1)
                cfg_write(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_W'($urandom));
            sh_zc = zc;
            sh_dc = dc;
            if (ph == 3) rx_hold_req <= 1'b1;
            for (k = 0; k < PHASE_WORDS; k++) begin
                // sender pause mid-stream until every result is in
                if (ph == 5 && k == PHASE_WORDS / 2) wait_drained(1'b0);
                send_random();
            end
        end

        wait_drained(1'b1);
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
rtl/udw_pkg.sv
rtl/udw_if.sv
rtl/unicode_display_width_core.sv
rtl/udw_checker.sv
bench/udw_width_checker.sv
bench/unicode_display_width_core_tb.sv
